// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, quiet in reset
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition that must hold on every clock out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

// ===== sv/tvfi_pkg.sv =====
// package: types, constants and helpers of the trilinear field sampler
`default_nettype none
package tvfi_pkg;
  localparam int POINTS_X = 16;
  localparam int POINTS_Y = 16;
  localparam int POINTS_Z = 16;
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_METHOD = 3'd6;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic METHOD_NEAREST = 1'b0;
  localparam logic METHOD_TRILINEAR = 1'b1;

  typedef struct packed {
    logic kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [3:0] grid_ix;
    logic [3:0] grid_iy;
    logic [3:0] grid_iz;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] entry_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAP, ST_LOOK, ST_READ, ST_LERP, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic map;        // grid mapping stage
    logic look;       // index and weight stage
    logic rd;         // issue corner read
    logic [2:0] corner;
    logic lerp;       // run one blend step
    logic [2:0] step;
    logic emit;       // drive result strobe
  } ctl_t;

  typedef struct packed {
    logic is_query;
    logic trilinear;
  } sts_t;
endpackage
`default_nettype wire

// ===== sv/tvfi_ctrl.sv =====
// controller state machine of the sampler
`default_nettype none
`include "assert_macros.svh"
module tvfi_ctrl import tvfi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);
  state_t state, state_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  // trilinear corner reads use counts 0..7, count 8 waits on the last read
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    case (state)
      ST_IDLE: if (start) state_next = ST_MAP;
      ST_MAP: begin
        if (sts.is_query) state_next = ST_LOOK;
        else state_next = ST_IDLE;
      end
      ST_LOOK: begin
        state_next = ST_READ;
        cnt_next = '0;
      end
      ST_READ: begin
        cnt_next = cnt + 4'd1;
        if (!sts.trilinear || cnt == 4'd8) begin
          if (!sts.trilinear && cnt != 4'd1) state_next = ST_READ;
          else begin
            state_next = sts.trilinear ? ST_LERP : ST_DONE;
            cnt_next = '0;
          end
        end
      end
      ST_LERP: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd6) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: ctl.load = start;
      ST_MAP: ctl.map = 1'b1;
      ST_LOOK: ctl.look = 1'b1;
      ST_READ: begin
        ctl.rd = 1'b1;
        ctl.corner = cnt[2:0];
        ctl.step = {2'b00, cnt[3]};
      end
      ST_LERP: begin
        ctl.lerp = 1'b1;
        ctl.step = cnt[2:0];
      end
      ST_DONE: ctl.emit = 1'b1;
      default: ctl = '0;
    endcase
  end

  `ASSERT_IMPL(a_emit_from_work, clk, rst, ctl.emit |-> $past(busy), "strobe without work")
  `ASSERT_IMPL(a_start_busy, clk, rst, (start && !busy) |=> busy, "start not taken")
  `ASSERT_ALWAYS(a_cnt_range, clk, rst, cnt <= 4'd8, "counter out of range")
endmodule
`default_nettype wire

// ===== sv/tvfi_datapath.sv =====
// datapath: grid mapping, component tables and blend unit
`default_nettype none
module tvfi_datapath import tvfi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  in_word_t din,
  input  wire logic cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  ctl_t ctl,
  output sts_t sts,
  output logic result_valid,
  output out_word_t result
);
  logic signed [31:0] org [3];
  logic [31:0] inv [3];
  logic meth;
  in_word_t w;
  logic [31:0] ux [3];      // saturated grid position, Q16.16
  logic [7:0] i0 [3];
  logic [7:0] i1 [3];
  logic [15:0] t [3];
  logic [31:0] memx [TABLE_DEPTH];
  logic [31:0] memy [TABLE_DEPTH];
  logic [31:0] memz [TABLE_DEPTH];
  logic signed [31:0] rdx, rdy, rdz;
  logic signed [31:0] cx [8];
  logic signed [31:0] cy [8];
  logic signed [31:0] cz [8];
  logic rd_d;
  logic [2:0] corner_d;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [7:0] sx, sy, sz;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      inv[0] <= 32'd65536; inv[1] <= 32'd65536; inv[2] <= 32'd65536;
      meth <= METHOD_TRILINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: org[0] <= cfg_data;
        REG_ORIGIN_Y: org[1] <= cfg_data;
        REG_ORIGIN_Z: org[2] <= cfg_data;
        REG_INV_X: inv[0] <= cfg_data;
        REG_INV_Y: inv[1] <= cfg_data;
        REG_INV_Z: inv[2] <= cfg_data;
        REG_METHOD: meth <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) if (ctl.load) w <= din;
  assign sts.is_query = (w.kind == KIND_QUERY);
  assign sts.trilinear = (meth == METHOD_TRILINEAR);

  // grid mapping: u = d*hi + (d*lo >> 16), saturated; one axis per lane
  logic signed [31:0] crd [3];
  assign crd[0] = w.coord_x;
  assign crd[1] = w.coord_y;
  assign crd[2] = w.coord_z;
  localparam logic [31:0] LIM [3] = '{32'((POINTS_X-1)*65536),
                                      32'((POINTS_Y-1)*65536),
                                      32'((POINTS_Z-1)*65536)};
  for (genvar k = 0; k < 3; k++) begin : g_map
    logic signed [32:0] d;
    logic [32:0] ud;
    logic [48:0] phi;
    logic [48:0] plo;
    logic [49:0] u;
    assign d = 33'(crd[k]) - 33'(org[k]);
    assign ud = d;
    assign phi = ud * inv[k][31:16];
    assign plo = ud * inv[k][15:0];
    assign u = 50'(phi) + 50'(plo[48:16]);
    always_ff @(posedge clk) begin
      if (ctl.map) begin
        if (d <= 0) ux[k] <= '0;
        else if (u > 50'(LIM[k])) ux[k] <= LIM[k];
        else ux[k] <= u[31:0];
      end
    end
    logic [7:0] fl;
    assign fl = ux[k][23:16];
    always_ff @(posedge clk) begin
      if (ctl.look) begin
        if (meth == METHOD_NEAREST) begin
          i0[k] <= 8'((ux[k] + 32'h8000) >> 16);
          i1[k] <= 8'((ux[k] + 32'h8000) >> 16);
          t[k] <= '0;
        end else begin
          i0[k] <= fl;
          i1[k] <= (32'(fl) + 1 > LIM[k] >> 16) ? 8'(LIM[k] >> 16) : fl + 8'd1;
          t[k] <= ux[k][15:0];
        end
      end
    end
  end

  // corner bit0 -> x, bit1 -> y, bit2 -> z
  assign sx = ctl.corner[0] ? i1[0] : i0[0];
  assign sy = ctl.corner[1] ? i1[1] : i0[1];
  assign sz = ctl.corner[2] ? i1[2] : i0[2];
  assign raddr = {sz[3:0], sy[3:0], sx[3:0]};
  logic oob;
  assign oob = (sx > 8'd15) || (sy > 8'd15) || (sz > 8'd15);
  logic oob_d;

  assign waddr = {w.grid_iz, w.grid_iy, w.grid_ix};
  assign wr_en = ctl.map && (w.kind == KIND_WRITE) &&
                 (32'(w.grid_ix) < POINTS_X) && (32'(w.grid_iy) < POINTS_Y) &&
                 (32'(w.grid_iz) < POINTS_Z);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      memx[waddr] <= w.entry_x;
      memy[waddr] <= w.entry_y;
      memz[waddr] <= w.entry_z;
    end
    rdx <= memx[raddr];
    rdy <= memy[raddr];
    rdz <= memz[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_d <= 1'b0;
    else rd_d <= ctl.rd && (ctl.step == 3'd0);
    corner_d <= ctl.corner;
    oob_d <= oob;
  end

  // blend unit: one lerp step a cycle, all three components in lanes
  logic [15:0] tw;
  logic [2:0] ia, ib, id;
  always_comb begin
    case (ctl.step)
      3'd0: begin ia = 3'd0; ib = 3'd1; id = 3'd0; tw = t[0]; end
      3'd1: begin ia = 3'd2; ib = 3'd3; id = 3'd2; tw = t[0]; end
      3'd2: begin ia = 3'd4; ib = 3'd5; id = 3'd4; tw = t[0]; end
      3'd3: begin ia = 3'd6; ib = 3'd7; id = 3'd6; tw = t[0]; end
      3'd4: begin ia = 3'd0; ib = 3'd2; id = 3'd0; tw = t[1]; end
      3'd5: begin ia = 3'd4; ib = 3'd6; id = 3'd4; tw = t[1]; end
      3'd6: begin ia = 3'd0; ib = 3'd4; id = 3'd0; tw = t[2]; end
      default: begin ia = 3'd0; ib = 3'd0; id = 3'd0; tw = '0; end
    endcase
  end

  function automatic logic signed [31:0] lerp_f(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [15:0] tt);
    logic signed [50:0] s;
    logic signed [50:0] m;
    s = 51'(a) * $signed({1'b0, 17'(17'd65536 - 17'(tt))}) +
        51'(b) * $signed({1'b0, tt});
    if (s < 0) begin
      m = ((-s) + 51'sd32768) >>> 16;
      lerp_f = 32'(-m);
    end else begin
      lerp_f = 32'((s + 51'sd32768) >>> 16);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rd_d) begin
      cx[corner_d] <= oob_d ? 32'sd0 : rdx;
      cy[corner_d] <= oob_d ? 32'sd0 : rdy;
      cz[corner_d] <= oob_d ? 32'sd0 : rdz;
    end else if (ctl.lerp) begin
      cx[id] <= lerp_f(cx[ia], cx[ib], tw);
      cy[id] <= lerp_f(cy[ia], cy[ib], tw);
      cz[id] <= lerp_f(cz[ia], cz[ib], tw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= ctl.emit;
    if (ctl.emit) begin
      result.field_x <= cx[0];
      result.field_y <= cy[0];
      result.field_z <= cz[0];
    end
  end
endmodule
`default_nettype wire

// ===== sv/trilinear_vector_field_interp.sv =====
// top level of the trilinear vector field sampler
//
// usage
//   a word is taken when start is high and busy is low; kind selects a
//   grid write (entry_* stored at grid_ix/iy/iz) or a query at coord_*
//   a query gives one result word on result, marked by result_valid for
//   one cycle; writes give none
//   configuration: cfg_we, cfg_index, cfg_data write one register per
//   cycle; write only while busy is low, the block does not enforce it
// sequence
//   write word: busy only in map, the state that writes the table
//   nearest query: busy through map, look, read and done, then a strobe
//   trilinear query: busy through map, look, eight corner reads, one per
//   cycle, through the single read port of the component tables, then
//   seven blend steps, one lerp per component for all steps, then done
// reset
//   rst (synchronous) returns the registers to origin 0, spacing 1.0 and
//   trilinear mode; table contents are left as they are
// the receiver cannot hold results off, so a result is lost if not taken
`default_nettype none
module trilinear_vector_field_interp import tvfi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  in_word_t din,
  input  wire logic cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic result_valid,
  output out_word_t result
);
  ctl_t ctl;
  sts_t sts;

  // sequencing of each word
  tvfi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  // mapping, tables and blend unit
  tvfi_datapath u_dp (
    .clk(clk), .rst(rst), .din(din), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .ctl(ctl), .sts(sts),
    .result_valid(result_valid), .result(result)
  );
endmodule
`default_nettype wire
